[rtl/srru_pkg.sv]
// Shared types and constants for the Sun raster pixel-data unpacker.
// No dependencies; used by the interfaces and all srru modules.
package srru_pkg;

  localparam int OUT_LANES_DEFAULT = 4;
  localparam int MAX_LANES         = 4;
  localparam int RESULTS_PER_BYTE  = 64;

  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int CNT_W   = 9;   // bytes pending in a run, up to 256
  localparam int LCNT_W  = 3;   // lane_count field
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h80;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNPACK_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_TOTAL = 1'd1;

  // unpack modes; the unused code behaves as raw copy
  localparam logic [1:0] MODE_RLE   = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_RAW32 = 2'd2;

  // escape decoder phases
  localparam logic [1:0] PH_LITERAL = 2'd0;
  localparam logic [1:0] PH_ESCAPE  = 2'd1;
  localparam logic [1:0] PH_COUNT   = 2'd2;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic emit;     // load one result into the output register
  } cmd_t;

  typedef struct packed {
    logic run_nonempty;  // the byte being offered yields at least one output byte
    logic run_last;      // pending run fits in one result
  } stat_t;

endpackage

[rtl/srru_if.sv]
// Valid/ready channels for input bytes and packed output results.
// Depends on srru_pkg for field widths.
interface srru_in_if;
  logic                         valid;
  logic                         ready;
  logic [srru_pkg::BYTE_W-1:0]  data_byte;
  logic                         start_image;
  logic                         file_end;

  modport source (output valid, data_byte, start_image, file_end, input ready);
  modport sink   (input valid, data_byte, start_image, file_end, output ready);
endinterface

interface srru_out_if;
  logic                         valid;
  logic                         ready;
  logic [srru_pkg::BYTE_W-1:0]  byte_lane0;
  logic [srru_pkg::BYTE_W-1:0]  byte_lane1;
  logic [srru_pkg::BYTE_W-1:0]  byte_lane2;
  logic [srru_pkg::BYTE_W-1:0]  byte_lane3;
  logic [srru_pkg::LCNT_W-1:0]  lane_count;
  logic                         last_of_run;
  logic                         image_done;

  modport source (output valid, byte_lane0, byte_lane1, byte_lane2, byte_lane3,
                  lane_count, last_of_run, image_done, input ready);
  modport sink   (input valid, byte_lane0, byte_lane1, byte_lane2, byte_lane3,
                  lane_count, last_of_run, image_done, output ready);
endinterface

[rtl/srru_ctrl.sv]
// Control FSM: input acceptance, run draining, output register valid.
// Depends on srru_pkg for cmd_t / stat_t.
module srru_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  srru_pkg::stat_t stat_i,
  output srru_pkg::cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic emit, accept, in_ready;

  always_comb begin
    emit     = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
    // next byte may enter on the cycle the last result of a run is loaded
    in_ready = (state_q == ST_IDLE) || (emit && stat_i.run_last);
    accept   = in_valid_i && in_ready;

    state_d = state_q;
    if (accept) begin
      state_d = stat_i.run_nonempty ? ST_RUN : ST_IDLE;
    end else if (emit && stat_i.run_last) begin
      state_d = ST_IDLE;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.emit   = emit;

endmodule

[rtl/srru_datapath.sv]
// Datapath: config registers, escape decoding, byte-total clamp, run counter
// and the output result register. Depends on srru_pkg.
module srru_datapath #(
  parameter int OUT_LANES = srru_pkg::OUT_LANES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srru_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srru_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [srru_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                             start_image_i,
  input  logic                             file_end_i,
  input  srru_pkg::cmd_t                   cmd_i,
  output srru_pkg::stat_t                  stat_o,
  output logic [srru_pkg::BYTE_W-1:0]      byte_lane0_o,
  output logic [srru_pkg::BYTE_W-1:0]      byte_lane1_o,
  output logic [srru_pkg::BYTE_W-1:0]      byte_lane2_o,
  output logic [srru_pkg::BYTE_W-1:0]      byte_lane3_o,
  output logic [srru_pkg::LCNT_W-1:0]      lane_count_o,
  output logic                             last_of_run_o,
  output logic                             image_done_o
);

  localparam int LANES = (OUT_LANES < 1) ? 1 :
                         (OUT_LANES > srru_pkg::MAX_LANES) ? srru_pkg::MAX_LANES : OUT_LANES;
  // longest run one byte may produce under the per-byte result limit
  localparam int MAX_RUN = srru_pkg::RESULTS_PER_BYTE * LANES;

  localparam int BW = srru_pkg::BYTE_W;
  localparam int TW = srru_pkg::TOTAL_W;
  localparam int CW = srru_pkg::CNT_W;
  localparam int LW = srru_pkg::LCNT_W;

  logic [1:0]    mode_q, mode_d;
  logic [TW-1:0] total_q, total_d;
  logic [1:0]    phase_q, phase_d;
  logic [BW-1:0] run_q, run_d;
  logic [TW-1:0] bw_q, bw_d;
  logic [1:0]    alpha_q, alpha_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [BW-1:0] val_q, val_d;

  logic [BW-1:0] lane_q [srru_pkg::MAX_LANES];
  logic [LW-1:0] lcnt_q;
  logic          last_q;
  logic          idone_q;

  // accept-side decode
  logic [TW-1:0] bw_eff;
  logic [1:0]    phase_eff, alpha_eff;
  logic [BW-1:0] run_eff;
  logic [TW:0]   diff;
  logic          discard;
  logic [TW-1:0] remain;
  logic [CW-1:0] n_raw, n_lim, n_fin;
  logic [BW-1:0] v_new;
  logic [1:0]    phase_new, alpha_new;
  logic [BW-1:0] run_new;
  logic          clip;

  // emit-side
  logic [LW-1:0] take;
  logic          run_last;

  always_comb begin
    bw_eff    = start_image_i ? '0 : bw_q;
    phase_eff = start_image_i ? srru_pkg::PH_LITERAL : phase_q;
    alpha_eff = start_image_i ? 2'd0 : alpha_q;
    run_eff   = start_image_i ? '0 : run_q;

    diff    = {1'b0, total_q} - {1'b0, bw_eff};
    discard = diff[TW] || (diff[TW-1:0] == '0);
    remain  = diff[TW-1:0];

    n_raw     = '0;
    v_new     = data_byte_i;
    phase_new = phase_eff;
    alpha_new = alpha_eff;
    run_new   = run_eff;

    case (mode_q)
      srru_pkg::MODE_RLE: begin
        case (phase_eff)
          srru_pkg::PH_ESCAPE: begin
            if (data_byte_i == srru_pkg::ZERO_BYTE) begin
              n_raw     = CW'(1);
              v_new     = srru_pkg::ESC_BYTE;
              phase_new = srru_pkg::PH_LITERAL;
            end else begin
              run_new   = data_byte_i;
              phase_new = srru_pkg::PH_COUNT;
            end
          end
          srru_pkg::PH_COUNT: begin
            n_raw     = {1'b0, run_eff} + CW'(1);
            phase_new = srru_pkg::PH_LITERAL;
            run_new   = '0;
          end
          default: begin
            if (data_byte_i == srru_pkg::ESC_BYTE) begin
              phase_new = srru_pkg::PH_ESCAPE;
            end else begin
              n_raw = CW'(1);
            end
          end
        endcase
        // escape cut off by end of file is dropped
        if (file_end_i && (phase_new != srru_pkg::PH_LITERAL)) begin
          phase_new = srru_pkg::PH_LITERAL;
          run_new   = '0;
        end
      end
      srru_pkg::MODE_RAW32: begin
        if (alpha_eff != 2'd0) begin
          n_raw = CW'(1);
        end
        alpha_new = alpha_eff + 2'd1;
      end
      default: begin
        n_raw = CW'(1);
      end
    endcase

    n_lim = (n_raw > CW'(MAX_RUN)) ? CW'(MAX_RUN) : n_raw;
    clip  = (remain[TW-1:CW] == '0) && (remain[CW-1:0] <= n_lim);
    n_fin = clip ? remain[CW-1:0] : n_lim;

    take     = (cnt_q < CW'(LANES)) ? cnt_q[LW-1:0] : LW'(LANES);
    run_last = (cnt_q == CW'(take));
  end

  assign stat_o.run_nonempty = !discard && (n_fin != '0);
  assign stat_o.run_last     = run_last;

  always_comb begin
    mode_d  = mode_q;
    total_d = total_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        srru_pkg::CFG_UNPACK_MODE:  mode_d  = cfg_data_i[1:0];
        srru_pkg::CFG_OUTPUT_TOTAL: total_d = cfg_data_i[TW-1:0];
        default: ;
      endcase
    end

    phase_d = phase_q;
    run_d   = run_q;
    alpha_d = alpha_q;
    bw_d    = bw_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    val_d   = val_q;

    if (cmd_i.emit) begin
      cnt_d = cnt_q - CW'(take);
    end

    if (cmd_i.accept) begin
      phase_d = phase_eff;
      run_d   = run_eff;
      alpha_d = alpha_eff;
      bw_d    = bw_eff;
      cnt_d   = '0;
      if (!discard) begin
        phase_d = phase_new;
        run_d   = run_new;
        alpha_d = alpha_new;
        bw_d    = bw_eff + TW'(n_fin);
        cnt_d   = n_fin;
        done_d  = clip;
        val_d   = v_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= srru_pkg::MODE_RLE;
      total_q <= '0;
      phase_q <= srru_pkg::PH_LITERAL;
      run_q   <= '0;
      alpha_q <= 2'd0;
      bw_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      total_q <= total_d;
      phase_q <= phase_d;
      run_q   <= run_d;
      alpha_q <= alpha_d;
      bw_q    <= bw_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (cmd_i.emit) begin
      for (int j = 0; j < srru_pkg::MAX_LANES; j++) begin
        lane_q[j] <= (LW'(j) < take) ? val_q : '0;
      end
      lcnt_q  <= take;
      last_q  <= run_last;
      idone_q <= run_last && done_q;
    end
  end

  assign byte_lane0_o  = lane_q[0];
  assign byte_lane1_o  = lane_q[1];
  assign byte_lane2_o  = lane_q[2];
  assign byte_lane3_o  = lane_q[3];
  assign lane_count_o  = lcnt_q;
  assign last_of_run_o = last_q;
  assign image_done_o  = idone_q;

endmodule

[rtl/sun_raster_rle_unpacker_core.sv]
// Sun raster pixel-data unpacker, top level. Uses srru_pkg, srru_if, srru_ctrl, srru_datapath.
// A byte's first result is loaded and made valid after the control FSM enters its run state.
// Throughput: one result per cycle from the run counter unless the output stalls; a byte
// yielding n output bytes holds input until its last result loads; literals stream 1/cycle.
// Reset (async, active low) clears config, decoder state, byte count and output valid.
module sun_raster_rle_unpacker_core #(
  parameter int OUT_LANES = srru_pkg::OUT_LANES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srru_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srru_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  srru_in_if.sink                          in_i,
  srru_out_if.source                       out_o
);

  srru_pkg::cmd_t  cmd;
  srru_pkg::stat_t stat;

  srru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srru_datapath #(
    .OUT_LANES (OUT_LANES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .data_byte_i   (in_i.data_byte),
    .start_image_i (in_i.start_image),
    .file_end_i    (in_i.file_end),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .byte_lane0_o  (out_o.byte_lane0),
    .byte_lane1_o  (out_o.byte_lane1),
    .byte_lane2_o  (out_o.byte_lane2),
    .byte_lane3_o  (out_o.byte_lane3),
    .lane_count_o  (out_o.lane_count),
    .last_of_run_o (out_o.last_of_run),
    .image_done_o  (out_o.image_done)
  );

endmodule
